### rtl/mmx_pkg.sv
`timescale 1ns / 1ps

package mmx_pkg;

   // Matrix geometry
   localparam int N_DIM = 4;
   localparam int ROW_W = $clog2(N_DIM);
   localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(N_DIM - 1);

   // Fixed-point formats
   localparam int ELEM_W    = 32;
   localparam int FRAC_BITS = 16;
   localparam int PROD_W    = 2 * ELEM_W;
   localparam int SP_W      = PROD_W - FRAC_BITS;   // shifted product
   localparam int SUM_W     = SP_W + ROW_W;         // four shifted products

   // Job queue between front and back
   localparam int QDEPTH = 2;
   localparam int QPTR_W = $clog2(QDEPTH);
   localparam int QCNT_W = $clog2(QDEPTH + 1);

   typedef logic signed [ELEM_W-1:0] elem_type;
   typedef elem_type [N_DIM-1:0]      row_type;
   typedef row_type  [N_DIM-1:0]      mat_type;

   typedef logic signed [PROD_W-1:0] prod_type;
   typedef prod_type [N_DIM-1:0]      prod_vec_type;

   typedef logic signed [SUM_W-1:0] sum_type;

   localparam elem_type ELEM_MAX = {1'b0, {(ELEM_W - 1){1'b1}}};
   localparam elem_type ELEM_MIN = {1'b1, {(ELEM_W - 1){1'b0}}};
   localparam sum_type  SUM_MAX  = SUM_W'(ELEM_MAX);
   localparam sum_type  SUM_MIN  = ~SUM_MAX;

   // Both operand matrices of one product
   typedef struct packed {
      mat_type left;
      mat_type right;
   } job_type;

   // Queue write side and queue head
   typedef struct packed {
      logic    valid;
      job_type job;
   } job_chan_type;

   typedef struct packed {
      logic     ovf;
      elem_type value;
   } sat_type;

   // Sum of four products, each floored by FRAC_BITS, saturated to ELEM_W
   function automatic sat_type sat_elem(input prod_vec_type p);
      sum_type  acc;
      prod_type sh;
      sat_type  r;
      acc = '0;
      for (int k = 0; k < N_DIM; k++) begin
         sh  = p[k] >>> FRAC_BITS;
         // shifted product fits in SP_W bits; keep its sign when widening
         acc = acc + sum_type'(signed'(sh[SP_W-1:0]));
      end
      if (acc > SUM_MAX) begin
         r.ovf   = 1'b1;
         r.value = ELEM_MAX;
      end else if (acc < SUM_MIN) begin
         r.ovf   = 1'b1;
         r.value = ELEM_MIN;
      end else begin
         r.ovf   = 1'b0;
         r.value = acc[ELEM_W-1:0];
      end
      return r;
   endfunction

endpackage

### rtl/mmx_req_if.sv
`timescale 1ns / 1ps

interface mmx_req_if;
   logic              valid;
   logic              ready;
   mmx_pkg::elem_type left_elem_0;
   mmx_pkg::elem_type left_elem_1;
   mmx_pkg::elem_type left_elem_2;
   mmx_pkg::elem_type left_elem_3;
   mmx_pkg::elem_type right_elem_0;
   mmx_pkg::elem_type right_elem_1;
   mmx_pkg::elem_type right_elem_2;
   mmx_pkg::elem_type right_elem_3;

   modport source (
      output valid, left_elem_0, left_elem_1, left_elem_2, left_elem_3,
             right_elem_0, right_elem_1, right_elem_2, right_elem_3,
      input  ready
   );

   modport sink (
      input  valid, left_elem_0, left_elem_1, left_elem_2, left_elem_3,
             right_elem_0, right_elem_1, right_elem_2, right_elem_3,
      output ready
   );
endinterface

### rtl/mmx_rsp_if.sv
`timescale 1ns / 1ps

interface mmx_rsp_if;
   logic                            valid;
   logic                            ready;
   mmx_pkg::elem_type               prod_elem_0;
   mmx_pkg::elem_type               prod_elem_1;
   mmx_pkg::elem_type               prod_elem_2;
   mmx_pkg::elem_type               prod_elem_3;
   logic [mmx_pkg::ROW_W-1:0]       out_row;
   logic                            last_row;
   logic                            overflow;

   modport source (
      output valid, prod_elem_0, prod_elem_1, prod_elem_2, prod_elem_3,
             out_row, last_row, overflow,
      input  ready
   );

   modport sink (
      input  valid, prod_elem_0, prod_elem_1, prod_elem_2, prod_elem_3,
             out_row, last_row, overflow,
      output ready
   );
endinterface

### rtl/mmx_front.sv
`timescale 1ns / 1ps

module mmx_front (
   input  logic                  clock,
   input  logic                  reset,
   mmx_req_if.sink               req,
   input  logic                  q_full,
   output mmx_pkg::job_chan_type push
);

   logic [mmx_pkg::ROW_W-1:0] row_count_ff;
   logic [mmx_pkg::ROW_W-1:0] row_count_in;
   mmx_pkg::row_type          left_ff  [mmx_pkg::N_DIM-1];
   mmx_pkg::row_type          right_ff [mmx_pkg::N_DIM-1];
   mmx_pkg::row_type          left_row;
   mmx_pkg::row_type          right_row;
   logic                      is_last;
   logic                      accept;

   always_comb begin
      left_row  = {req.left_elem_3, req.left_elem_2, req.left_elem_1, req.left_elem_0};
      right_row = {req.right_elem_3, req.right_elem_2, req.right_elem_1, req.right_elem_0};
      is_last   = (row_count_ff == mmx_pkg::LAST_ROW);
      // only the closing row needs a free queue slot
      req.ready = !(q_full && is_last);
      accept    = req.valid && req.ready;
      row_count_in = accept ? row_count_ff + 1'b1 : row_count_ff;

      push.valid      = accept && is_last;
      push.job.left   = {left_row, left_ff[2], left_ff[1], left_ff[0]};
      push.job.right  = {right_row, right_ff[2], right_ff[1], right_ff[0]};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_count_ff <= '0;
      end else begin
         row_count_ff <= row_count_in;
      end
   end

   // rows 0..2 held here; row 3 goes straight into the queue
   always_ff @(posedge clock) begin
      if (accept && !is_last) begin
         left_ff[row_count_ff]  <= left_row;
         right_ff[row_count_ff] <= right_row;
      end
   end

endmodule

### rtl/mmx_queue.sv
`timescale 1ns / 1ps

module mmx_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  mmx_pkg::job_chan_type push,
   input  logic                  pop,
   output logic                  full,
   output mmx_pkg::job_chan_type head
);

   mmx_pkg::job_type           q_ff [mmx_pkg::QDEPTH];
   logic [mmx_pkg::QPTR_W-1:0] wr_ptr_ff;
   logic [mmx_pkg::QPTR_W-1:0] rd_ptr_ff;
   logic [mmx_pkg::QCNT_W-1:0] count_ff;
   logic [mmx_pkg::QCNT_W-1:0] count_in;

   always_comb begin
      full       = (count_ff == mmx_pkg::QCNT_W'(mmx_pkg::QDEPTH));
      head.valid = (count_ff != '0);
      head.job   = q_ff[rd_ptr_ff];
      count_in   = count_ff + mmx_pkg::QCNT_W'(push.valid) - mmx_pkg::QCNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push.valid) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.valid) begin
         q_ff[wr_ptr_ff] <= push.job;
      end
   end

`ifndef SYNTHESIS
   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      !(push.valid && full && !pop))
      else $error("job pushed into full queue");

   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      pop |-> head.valid)
      else $error("job popped from empty queue");
`endif

endmodule

### rtl/mmx_back.sv
`timescale 1ns / 1ps

module mmx_back (
   input  logic                  clock,
   input  logic                  reset,
   input  mmx_pkg::job_chan_type head,
   output logic                  pop,
   mmx_rsp_if.source             rsp
);

   logic [mmx_pkg::ROW_W-1:0] issue_row_ff;
   logic [mmx_pkg::ROW_W-1:0] issue_row_in;
   logic                      adv;
   logic                      issue;
   mmx_pkg::row_type          a_row;

   // multiply stage
   logic                      p_valid_ff;
   logic                      p_valid_in;
   logic [mmx_pkg::ROW_W-1:0] p_row_ff;
   mmx_pkg::prod_vec_type     p_prod_ff [mmx_pkg::N_DIM];
   mmx_pkg::prod_vec_type     p_prod_in [mmx_pkg::N_DIM];

   // sum / saturate into output register
   mmx_pkg::sat_type          sat [mmx_pkg::N_DIM];
   logic                      row_ovf;
   logic                      rsp_valid_ff;
   logic                      rsp_valid_in;
   mmx_pkg::elem_type         rsp_elem_ff [mmx_pkg::N_DIM];
   logic [mmx_pkg::ROW_W-1:0] rsp_row_ff;
   logic                      rsp_ovf_ff;

   always_comb begin
      adv   = !rsp_valid_ff || rsp.ready;
      issue = adv && head.valid;
      pop   = issue && (issue_row_ff == mmx_pkg::LAST_ROW);
      issue_row_in = issue ? issue_row_ff + 1'b1 : issue_row_ff;
      p_valid_in   = adv ? head.valid : p_valid_ff;
      rsp_valid_in = adv ? p_valid_ff : rsp_valid_ff;

      a_row = head.job.left[issue_row_ff];
      for (int j = 0; j < mmx_pkg::N_DIM; j++) begin
         for (int k = 0; k < mmx_pkg::N_DIM; k++) begin
            p_prod_in[j][k] = mmx_pkg::prod_type'(a_row[k])
                            * mmx_pkg::prod_type'(head.job.right[k][j]);
         end
      end

      row_ovf = 1'b0;
      for (int j = 0; j < mmx_pkg::N_DIM; j++) begin
         sat[j]  = mmx_pkg::sat_elem(p_prod_ff[j]);
         row_ovf = row_ovf | sat[j].ovf;
      end

      rsp.valid       = rsp_valid_ff;
      rsp.prod_elem_0 = rsp_elem_ff[0];
      rsp.prod_elem_1 = rsp_elem_ff[1];
      rsp.prod_elem_2 = rsp_elem_ff[2];
      rsp.prod_elem_3 = rsp_elem_ff[3];
      rsp.out_row     = rsp_row_ff;
      rsp.last_row    = (rsp_row_ff == mmx_pkg::LAST_ROW);
      rsp.overflow    = rsp_ovf_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         issue_row_ff <= '0;
         p_valid_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         issue_row_ff <= issue_row_in;
         p_valid_ff   <= p_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         p_row_ff   <= issue_row_ff;
         p_prod_ff  <= p_prod_in;
         rsp_row_ff <= p_row_ff;
         rsp_ovf_ff <= row_ovf;
         for (int j = 0; j < mmx_pkg::N_DIM; j++) begin
            rsp_elem_ff[j] <= sat[j].value;
         end
      end
   end

`ifndef SYNTHESIS
   a_stage_hold: assert property (@(posedge clock) disable iff (reset)
      p_valid_ff && !adv |=> p_valid_ff && $stable(p_row_ff))
      else $error("multiply stage lost its row under stall");

   a_issue_row: assert property (@(posedge clock) disable iff (reset)
      issue |=> p_valid_ff && (p_row_ff == $past(issue_row_ff)))
      else $error("issued row not captured in multiply stage");

   a_row_order: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp.ready && (rsp_row_ff != mmx_pkg::LAST_ROW) && p_valid_ff
      |=> rsp_valid_ff && (rsp_row_ff == mmx_pkg::ROW_W'($past(rsp_row_ff) + 1'b1)))
      else $error("result rows out of order");
`endif

endmodule

### rtl/matrix_multiply_4x4_core.sv
`timescale 1ns / 1ps

// 4x4 signed Q16.16 matrix multiply, C = A * B. Each req item carries row i
// of A and row i of B (rows counted 0..3, wrapping). The item that closes row 3
// hands both matrices to a two-entry job queue; the back end then emits the
// four rows of C in order on rsp, one per cycle while rsp is ready, with
// last_row on row 3 and overflow when any element of that row saturated.
// Each element is the sum of four exact 64-bit products, each floored by 16
// fraction bits, saturated to 32 bits. Rate: one req item per cycle unless
// the closing row meets a full queue, one rsp item per cycle while ready;
// four C rows per matrix match the 4 row items that feed it. The closing
// item's job passes the queue write, the multiply stage, then sum/saturate
// into the output register. rows 0..2 never stall; the closing row waits
// only while both queue entries are occupied. No clearing pass after reset.
module matrix_multiply_4x4_core (
   input  logic       clock,
   input  logic       reset,
   mmx_req_if.sink    req_ch,
   mmx_rsp_if.source  rsp_ch
);

   mmx_pkg::job_chan_type push;    // front -> queue
   mmx_pkg::job_chan_type head;    // queue -> back
   logic                  q_full;
   logic                  pop;

   // Front: row counter, holding rows 0..2, pushing the full job
   mmx_front u_front (
      .clock  (clock),
      .reset  (reset),
      .req    (req_ch),
      .q_full (q_full),
      .push   (push)
   );

   // Decouples input rows from result rows: a new matrix can load
   // while the previous one is still being drained.
   mmx_queue u_queue (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .pop   (pop),
      .full  (q_full),
      .head  (head)
   );

   // Back: 16 multipliers per row, then add/saturate into the rsp register
   mmx_back u_back (
      .clock (clock),
      .reset (reset),
      .head  (head),
      .pop   (pop),
      .rsp   (rsp_ch)
   );

endmodule

### tb/tb_top.sv
`timescale 1ns / 1ps

// Self-checking bench for matrix_multiply_4x4_core.
// A driver feeds row items (row i of A, row i of B) from a queue that the
// initial block fills. A monitor checks every C row against a predictor.
// The predictor keeps its own copy of both operand stores and of the row
// counter.
module tb_top;

   localparam int HALF_PERIOD   = 6;
   localparam int RESET_CYCLES  = 6;
   localparam int DIRECTED_MATS = 4;
   localparam int RANDOM_MATS   = 111;
   localparam int TOTAL_ROWS    = (DIRECTED_MATS + RANDOM_MATS) * mmx_pkg::N_DIM;
   localparam int MAX_IDLE      = 12;
   localparam int HOLD_AT_ROW   = 120;    // rsp side goes deaf here
   localparam int HOLD_CYCLES   = 150;
   localparam int DRAIN_AT_ROW  = 240;    // must start a matrix (multiple of 4)
   localparam int SETTLE_CYCLES = 20;
   localparam int CYCLE_LIMIT   = 200000;

   localparam longint            SAT_HI = 64'sd2147483647;
   localparam longint            SAT_LO = -64'sd2147483648;
   localparam mmx_pkg::elem_type Q_ONE  = 32'sh0001_0000;   // 1.0 in Q16.16

   // Value mix used when filling a random matrix
   typedef enum logic [1:0] {
      FILL_FULL,      // any 32-bit pattern
      FILL_SMALL,     // within +/-16.0, never saturates when both operands use it
      FILL_MEDIUM,    // within +/-128.0, sums sit near the 32-bit edge
      FILL_CORNER     // extremes, zero, +/-1 lsb, +/-1.0, or any 32-bit pattern
   } fill_style_type;

   typedef struct packed {
      logic             drain_first;   // hold this item until no C row is pending
      mmx_pkg::row_type a_row;
      mmx_pkg::row_type b_row;
   } row_item_type;

   typedef struct packed {
      mmx_pkg::row_type          elems;
      logic [mmx_pkg::ROW_W-1:0] row;
      logic                      last;
      logic                      ovf;
   } c_row_type;

   logic clock;
   logic reset;

   mmx_req_if req_if ();
   mmx_rsp_if rsp_if ();

   matrix_multiply_4x4_core DUT (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_if),
      .rsp_ch (rsp_if)
   );

   always #HALF_PERIOD clock = ~clock;

   // ---------------------------------------------------------------------
   // Shared bench state
   // ---------------------------------------------------------------------
   row_item_type pending_rows[$];    // stimulus not yet offered
   c_row_type    product_rows[$];    // C rows predicted, not yet seen
   row_item_type cur_row;            // item currently on req
   int           rows_queued;
   int           rows_taken;
   int           mismatches;
   int           cycles;
   int unsigned  gap_left;
   int unsigned  stall_left;
   int unsigned  hold_left;
   bit           hold_done;
   bit           req_fire;

   // Predictor state: A and B stores plus the wrapping row counter
   mmx_pkg::elem_type         a_store [mmx_pkg::N_DIM][mmx_pkg::N_DIM];
   mmx_pkg::elem_type         b_store [mmx_pkg::N_DIM][mmx_pkg::N_DIM];
   logic [mmx_pkg::ROW_W-1:0] row_slot;

   function automatic mmx_pkg::row_type mk_row(input mmx_pkg::elem_type e0,
                                               input mmx_pkg::elem_type e1,
                                               input mmx_pkg::elem_type e2,
                                               input mmx_pkg::elem_type e3);
      mmx_pkg::row_type r;
      r[0] = e0;
      r[1] = e1;
      r[2] = e2;
      r[3] = e3;
      return r;
   endfunction

   // Idle cycles before the next item on either side. Every third stretch
   // of 48 rows runs with no idling at all, and during the long rsp hold
   // the sender keeps pushing back to back.
   function automatic int unsigned idle_draw();
      if (hold_left > 0 || ((rows_taken / 48) % 3) == 1)
         return 0;
      return $urandom_range(0, MAX_IDLE);
   endfunction

   function automatic mmx_pkg::elem_type draw_elem(input fill_style_type style);
      case (style)
         FILL_SMALL:
            return mmx_pkg::elem_type'(int'($urandom_range(0, 2097151)) - 1048576);
         FILL_MEDIUM:
            return mmx_pkg::elem_type'(int'($urandom_range(0, 16777215)) - 8388608);
         FILL_CORNER: begin
            case ($urandom_range(0, 7))
               0:       return mmx_pkg::ELEM_MAX;
               1:       return mmx_pkg::ELEM_MIN;
               2:       return '0;
               3:       return -1;
               4:       return 1;
               5:       return Q_ONE;
               6:       return -Q_ONE;
               default: return mmx_pkg::elem_type'($urandom);
            endcase
         end
         default:     return mmx_pkg::elem_type'($urandom);
      endcase
   endfunction

   task automatic queue_row(input mmx_pkg::row_type a, input mmx_pkg::row_type b);
      row_item_type it;
      it.a_row       = a;
      it.b_row       = b;
      it.drain_first = (rows_queued == DRAIN_AT_ROW);
      pending_rows.push_back(it);
      rows_queued++;
   endtask

   // Store one accepted row item. On the row that closes the matrix,
   // compute all four C rows: exact 64-bit products, floor by the fraction
   // bits, exact sum, then saturate to 32 bits.
   task automatic absorb_row(input row_item_type it);
      longint    acc;
      c_row_type cr;
      for (int k = 0; k < mmx_pkg::N_DIM; k++) begin
         a_store[row_slot][k] = it.a_row[k];
         b_store[row_slot][k] = it.b_row[k];
      end
      if (row_slot == mmx_pkg::LAST_ROW) begin
         for (int i = 0; i < mmx_pkg::N_DIM; i++) begin
            cr      = '0;
            cr.row  = mmx_pkg::ROW_W'(i);
            cr.last = (i == mmx_pkg::N_DIM - 1);
            for (int j = 0; j < mmx_pkg::N_DIM; j++) begin
               acc = 0;
               for (int k = 0; k < mmx_pkg::N_DIM; k++)
                  acc += (longint'(a_store[i][k]) * longint'(b_store[k][j]))
                         >>> mmx_pkg::FRAC_BITS;
               if (acc > SAT_HI) begin
                  cr.elems[j] = mmx_pkg::ELEM_MAX;
                  cr.ovf      = 1'b1;
               end else if (acc < SAT_LO) begin
                  cr.elems[j] = mmx_pkg::ELEM_MIN;
                  cr.ovf      = 1'b1;
               end else begin
                  cr.elems[j] = acc[mmx_pkg::ELEM_W-1:0];
               end
            end
            product_rows.push_back(cr);
         end
      end
      row_slot = row_slot + 1'b1;
   endtask

   task automatic note_error(input string msg);
      $display("ERROR @%0t: %s", $time, msg);
      mismatches++;
   endtask

   task automatic check_result();
      c_row_type        want;
      mmx_pkg::row_type got;
      if (product_rows.size() == 0) begin
         note_error($sformatf("C row %0d arrived with none expected", rsp_if.out_row));
         return;
      end
      want = product_rows.pop_front();
      got  = mk_row(rsp_if.prod_elem_0, rsp_if.prod_elem_1,
                    rsp_if.prod_elem_2, rsp_if.prod_elem_3);
      for (int j = 0; j < mmx_pkg::N_DIM; j++)
         if (got[j] !== want.elems[j])
            note_error($sformatf("C row %0d elem %0d: expected %0d got %0d",
                                 want.row, j, want.elems[j], got[j]));
      if (rsp_if.out_row !== want.row)
         note_error($sformatf("out_row: expected %0d got %0d", want.row, rsp_if.out_row));
      if (rsp_if.last_row !== want.last)
         note_error($sformatf("C row %0d last_row: expected %0b got %0b",
                              want.row, want.last, rsp_if.last_row));
      if (rsp_if.overflow !== want.ovf)
         note_error($sformatf("C row %0d overflow: expected %0b got %0b",
                              want.row, want.ovf, rsp_if.overflow));
   endtask

   // ---------------------------------------------------------------------
   // Driver: one item at a time from pending_rows, random gap after each
   // accepted item. valid is held until the item is taken.
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         req_if.valid <= 1'b0;
         gap_left = 0;
         row_slot = '0;
      end else begin
         req_fire = req_if.valid && req_if.ready;
         if (req_fire) begin
            absorb_row(cur_row);
            rows_taken++;
            gap_left = idle_draw();
         end
         if (!req_if.valid || req_fire) begin
            if (gap_left > 0) begin
               gap_left--;
               req_if.valid <= 1'b0;
            end else if (pending_rows.size() > 0 &&
                         (!pending_rows[0].drain_first || product_rows.size() == 0)) begin
               cur_row = pending_rows.pop_front();
               req_if.valid        <= 1'b1;
               req_if.left_elem_0  <= cur_row.a_row[0];
               req_if.left_elem_1  <= cur_row.a_row[1];
               req_if.left_elem_2  <= cur_row.a_row[2];
               req_if.left_elem_3  <= cur_row.a_row[3];
               req_if.right_elem_0 <= cur_row.b_row[0];
               req_if.right_elem_1 <= cur_row.b_row[1];
               req_if.right_elem_2 <= cur_row.b_row[2];
               req_if.right_elem_3 <= cur_row.b_row[3];
            end else begin
               req_if.valid <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // Monitor: checks each accepted C row, then drops ready for a random
   // stall. Once, after HOLD_AT_ROW rows are taken, ready is held low so the
   // job queue fills and req backs up.
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
         stall_left = 0;
         hold_left  = 0;
         hold_done  = 1'b0;
      end else begin
         if (rsp_if.valid && rsp_if.ready) begin
            check_result();
            stall_left = idle_draw();
         end
         if (!hold_done && rows_taken >= HOLD_AT_ROW) begin
            hold_left = HOLD_CYCLES;
            hold_done = 1'b1;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_if.ready <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_if.ready <= 1'b0;
         end else begin
            rsp_if.ready <= 1'b1;
         end
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycles++;
      if (cycles >= CYCLE_LIMIT) begin
         $display("tb_top NOT OK");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // Stimulus and end of run
   // ---------------------------------------------------------------------
   initial begin
      fill_style_type sa;
      fill_style_type sb;

      clock               = 1'b0;
      reset               = 1'b1;
      req_if.valid        = 1'b0;
      req_if.left_elem_0  = '0;
      req_if.left_elem_1  = '0;
      req_if.left_elem_2  = '0;
      req_if.left_elem_3  = '0;
      req_if.right_elem_0 = '0;
      req_if.right_elem_1 = '0;
      req_if.right_elem_2 = '0;
      req_if.right_elem_3 = '0;
      rsp_if.ready        = 1'b0;
      rows_queued         = 0;
      rows_taken          = 0;
      mismatches          = 0;
      cycles              = 0;

      // Full scale times full scale: every element saturates high.
      for (int i = 0; i < mmx_pkg::N_DIM; i++)
         queue_row(mk_row(mmx_pkg::ELEM_MAX, mmx_pkg::ELEM_MAX,
                          mmx_pkg::ELEM_MAX, mmx_pkg::ELEM_MAX),
                   mk_row(mmx_pkg::ELEM_MAX, mmx_pkg::ELEM_MAX,
                          mmx_pkg::ELEM_MAX, mmx_pkg::ELEM_MAX));

      // Most negative A: saturates low (col 0) and high (col 1), zero
      // column, and an exact small negative column.
      for (int i = 0; i < mmx_pkg::N_DIM; i++)
         queue_row(mk_row(mmx_pkg::ELEM_MIN, mmx_pkg::ELEM_MIN,
                          mmx_pkg::ELEM_MIN, mmx_pkg::ELEM_MIN),
                   mk_row(mmx_pkg::ELEM_MAX, mmx_pkg::ELEM_MIN, 0, 1));

      // Identity A: C equals B, extremes pass through unchanged.
      queue_row(mk_row(Q_ONE, 0, 0, 0), mk_row(mmx_pkg::ELEM_MAX, mmx_pkg::ELEM_MIN, 0, -1));
      queue_row(mk_row(0, Q_ONE, 0, 0), mk_row(1, -1, 65535, -65536));
      queue_row(mk_row(0, 0, Q_ONE, 0), mk_row(mmx_pkg::ELEM_MIN, mmx_pkg::ELEM_MAX, -1, 1));
      queue_row(mk_row(0, 0, 0, Q_ONE), mk_row(0, 0, 0, 0));

      // Floor of negative products (row 0 of C). Rows 1 and 2 land exactly
      // on the high limit and one lsb below the low one; row 3 lands just
      // past the high limit.
      queue_row(mk_row(-1, -1, -1, -1),
                mk_row(1, 65535, mmx_pkg::ELEM_MAX, mmx_pkg::ELEM_MIN));
      queue_row(mk_row(Q_ONE, Q_ONE, 0, 0), mk_row(3, 65536, 0, -1));
      queue_row(mk_row(Q_ONE, Q_ONE, 0, 0), mk_row(-1, -65535, 7, 9));
      queue_row(mk_row(-Q_ONE, -Q_ONE, 0, 0), mk_row(5, 6, 7, 8));

      // Random matrices, value mix picked per operand per matrix
      for (int m = 0; m < RANDOM_MATS; m++) begin
         sa = fill_style_type'($urandom_range(0, 3));
         sb = fill_style_type'($urandom_range(0, 3));
         for (int i = 0; i < mmx_pkg::N_DIM; i++)
            queue_row(mk_row(draw_elem(sa), draw_elem(sa), draw_elem(sa), draw_elem(sa)),
                      mk_row(draw_elem(sb), draw_elem(sb), draw_elem(sb), draw_elem(sb)));
      end

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      while (rows_taken < TOTAL_ROWS) @(posedge clock);
      while (product_rows.size() != 0) @(posedge clock);
      // Any extra C row arriving now shows up as unexpected.
      repeat (SETTLE_CYCLES) @(posedge clock);

      if (mismatches == 0 && product_rows.size() == 0)
         $display("tb_top OK");
      else
         $display("tb_top NOT OK");
      $finish;
   end

endmodule
